@@ sv/image_to_column_engine_macros.svh @@
`ifndef IMAGE_TO_COLUMN_ENGINE_MACROS_SVH
`define IMAGE_TO_COLUMN_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ITC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itc assertion failed");

// next-cycle implication, checked outside reset
`define ITC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itc assertion failed");

`endif

@@ sv/itc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package itc_pkg;

  localparam int unsigned MaxDim      = 64;
  localparam int unsigned MaxChannels = 64;
  localparam int unsigned MaxKernel   = 15;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned PixAddrW = 12;
  localparam int unsigned DataW    = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned ColAddrW = 20;

  localparam logic [CmdW-1:0] CMD_WRITE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_READ   = 3'd1;
  localparam logic [CmdW-1:0] CMD_IM2COL = 3'd2;
  localparam logic [CmdW-1:0] CMD_COL2IM = 3'd3;
  localparam logic [CmdW-1:0] CMD_REWIND = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_CHANNELS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KERNEL   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEP     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PAD      = 3'd5;

  localparam logic [StatusW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatusW-1:0] STAT_RANGE = 2'd1;
  localparam logic [StatusW-1:0] STAT_GEOM  = 2'd2;
  localparam logic [StatusW-1:0] STAT_SAT   = 2'd3;

  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_COL,
    KIND_ACC,
    KIND_REWIND,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic                addr_oob;
    logic [PixAddrW-1:0] addr;
    logic [DataW-1:0]    data;
  } item_t;

endpackage

`default_nettype wire

@@ sv/itc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module itc_front import itc_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CmdW-1:0]            cmd_i,
  input  logic [PixAddrW-1:0]        pixel_addr_i,
  input  logic signed [DataW-1:0]    data_value_i,
  output item_t                      item_o,
  output logic                       item_valid_o,
  input  logic                       item_pop_i
);

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  item_t       incoming;
  logic        push, pop;

  always_comb begin
    incoming.addr     = pixel_addr_i;
    incoming.data     = data_value_i;
    incoming.addr_oob = (32'(pixel_addr_i) >= STORE_DEPTH);
    unique case (cmd_i)
      CMD_WRITE:  incoming.kind = KIND_WRITE;
      CMD_READ:   incoming.kind = KIND_READ;
      CMD_IM2COL: incoming.kind = KIND_COL;
      CMD_COL2IM: incoming.kind = KIND_ACC;
      CMD_REWIND: incoming.kind = KIND_REWIND;
      default:    incoming.kind = KIND_NOP;
    endcase
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

`default_nettype wire

@@ sv/itc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "image_to_column_engine_macros.svh"

module itc_back import itc_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  item_t                      item_i,
  input  logic                       item_valid_i,
  output logic                       item_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DataW-1:0]    result_value_o,
  output logic [PixAddrW-1:0]        source_addr_o,
  output logic                       in_bounds_o,
  output logic                       last_element_o,
  output logic [StatusW-1:0]         status_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_POS  = 5'b00010,
    ST_ADDR = 5'b00100,
    ST_RD   = 5'b01000,
    ST_EX   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // geometry registers
  logic [6:0] cc_q, ih_q, iw_q;
  logic [3:0] ks_q, ss_q, bp_q;

  // column walk
  logic [3:0] kcol_q, kcol_d, krow_q, krow_d;
  logic [5:0] kch_q, kch_d;
  logic [6:0] orow_q, orow_d, ocol_q, ocol_d;

  item_t cur_q;

  logic                geom_q, last_q, inside_q, aoob_q;
  logic [5:0]          r_q, c_q;
  logic [12:0]         hch_q;
  logic [ColAddrW-1:0] a_q;
  logic [DataW-1:0]    rdata_q;
  logic [DataW-1:0]    mem_q [STORE_DEPTH];

  logic                out_valid_q;
  logic [DataW-1:0]    res_q, res_d;
  logic [PixAddrW-1:0] src_q, src_d;
  logic                inb_q, inb_d, lst_q, lst_d;
  logic [StatusW-1:0]  stat_q, stat_d;

  logic [7:0]  hpad, wpad, dh, dw;
  logic        geom_ok;
  logic [10:0] orow_s, ocol_s;
  logic [11:0] row_next, col_next, prow, pcol, prow_r, pcol_c;
  logic        row_wrap, col_wrap, row_end, col_end;
  logic        kcol_wrap, krow_wrap, kch_wrap, kcol_end, krow_end, kch_end;
  logic        walk_last, in_image;
  logic [12:0] hch, tpos;
  logic [ColAddrW-1:0] a_calc;
  logic [31:0] pix_wide, a_wide;
  logic [AW-1:0] mem_idx;
  logic          is_col;
  logic [32:0]   sum;
  logic [DataW-1:0] sat, wdata;
  logic          sat_hit, mem_we, ex_fire, rewind_fire;

  // geometry check and walk limits
  always_comb begin
    hpad    = {1'b0, ih_q} + {3'b000, bp_q, 1'b0};
    wpad    = {1'b0, iw_q} + {3'b000, bp_q, 1'b0};
    dh      = hpad - 8'(ks_q);
    dw      = wpad - 8'(ks_q);
    geom_ok = (cc_q != 7'd0) && (32'(cc_q) <= MaxChannels) &&
              (ih_q != 7'd0) && (32'(ih_q) <= MaxDim) &&
              (iw_q != 7'd0) && (32'(iw_q) <= MaxDim) &&
              (ks_q != 4'd0) && (32'(ks_q) <= MaxKernel) &&
              (ss_q != 4'd0) && (hpad >= 8'(ks_q)) && (wpad >= 8'(ks_q));
  end

  // output-axis wrap tests via position * step against the padded span less the kernel size
  always_comb begin
    orow_s    = {4'b0000, orow_q} * {7'b0000000, ss_q};
    ocol_s    = {4'b0000, ocol_q} * {7'b0000000, ss_q};
    row_next  = 12'(orow_s) + 12'(ss_q);
    col_next  = 12'(ocol_s) + 12'(ss_q);
    row_wrap  = row_next > 12'(dh);
    col_wrap  = col_next > 12'(dw);
    row_end   = (12'(orow_s) <= 12'(dh)) && row_wrap;
    col_end   = (12'(ocol_s) <= 12'(dw)) && col_wrap;
    kcol_wrap = (5'(kcol_q) + 5'd1) >= 5'(ks_q);
    krow_wrap = (5'(krow_q) + 5'd1) >= 5'(ks_q);
    kch_wrap  = (7'(kch_q) + 7'd1) >= cc_q;
    kcol_end  = (5'(kcol_q) + 5'd1) == 5'(ks_q);
    krow_end  = (5'(krow_q) + 5'd1) == 5'(ks_q);
    kch_end   = (7'(kch_q) + 7'd1) == cc_q;
    walk_last = col_end && row_end && kcol_end && krow_end && kch_end;
    prow      = 12'(krow_q) + 12'(orow_s);
    pcol      = 12'(kcol_q) + 12'(ocol_s);
    prow_r    = prow - 12'(bp_q);
    pcol_c    = pcol - 12'(bp_q);
    in_image  = (prow >= 12'(bp_q)) && (pcol >= 12'(bp_q)) &&
                (prow_r < 12'(ih_q)) && (pcol_c < 12'(iw_q)) &&
                (7'(kch_q) < cc_q);
    hch       = {6'b000000, ih_q} * {7'b0000000, kch_q};
  end

  always_comb begin
    ocol_d = ocol_q;
    orow_d = orow_q;
    kcol_d = kcol_q;
    krow_d = krow_q;
    kch_d  = kch_q;
    if (rewind_fire) begin
      ocol_d = '0;
      orow_d = '0;
      kcol_d = '0;
      krow_d = '0;
      kch_d  = '0;
    end else if (state_q == ST_POS && geom_ok) begin
      ocol_d = col_wrap ? 7'd0 : ocol_q + 7'd1;
      if (col_wrap) begin
        orow_d = row_wrap ? 7'd0 : orow_q + 7'd1;
        if (row_wrap) begin
          kcol_d = kcol_wrap ? 4'd0 : kcol_q + 4'd1;
          if (kcol_wrap) begin
            krow_d = krow_wrap ? 4'd0 : krow_q + 4'd1;
            if (krow_wrap) begin
              kch_d = kch_wrap ? 6'd0 : kch_q + 6'd1;
            end
          end
        end
      end
    end
  end

  // store address
  always_comb begin
    tpos     = 13'(r_q) + hch_q;
    a_calc   = ColAddrW'(c_q) + ColAddrW'(iw_q) * ColAddrW'(tpos);
    pix_wide = 32'(cur_q.addr);
    a_wide   = 32'(a_q);
    is_col   = (cur_q.kind == KIND_COL) || (cur_q.kind == KIND_ACC);
    mem_idx  = is_col ? a_wide[AW-1:0] : pix_wide[AW-1:0];
  end

  assign ex_fire     = (state_q == ST_EX) && (!out_valid_q || !out_stall_i);
  assign rewind_fire = ex_fire && (cur_q.kind == KIND_REWIND);
  assign item_pop_o  = (state_q == ST_IDLE) && item_valid_i;

  // execute: result word and store update
  always_comb begin
    res_d   = '0;
    src_d   = '0;
    inb_d   = 1'b0;
    lst_d   = 1'b0;
    stat_d  = STAT_OK;
    mem_we  = 1'b0;
    wdata   = cur_q.data;
    sum     = {rdata_q[DataW-1], rdata_q} + {cur_q.data[DataW-1], cur_q.data};
    sat     = sum[DataW-1:0];
    sat_hit = 1'b0;
    if (sum[32:31] == 2'b01) begin
      sat     = 32'h7fff_ffff;
      sat_hit = 1'b1;
    end else if (sum[32:31] == 2'b10) begin
      sat     = 32'h8000_0000;
      sat_hit = 1'b1;
    end
    unique case (cur_q.kind)
      KIND_WRITE, KIND_READ: begin
        src_d = cur_q.addr;
        if (cur_q.addr_oob) begin
          stat_d = STAT_RANGE;
        end else if (cur_q.kind == KIND_WRITE) begin
          res_d  = cur_q.data;
          mem_we = 1'b1;
        end else begin
          res_d = rdata_q;
        end
      end
      KIND_COL, KIND_ACC: begin
        if (!geom_q) begin
          stat_d = STAT_GEOM;
        end else begin
          lst_d = last_q;
          if (inside_q) begin
            inb_d = 1'b1;
            if (aoob_q) begin
              stat_d = STAT_RANGE;
            end else begin
              src_d = PixAddrW'(a_q);
              if (cur_q.kind == KIND_COL) begin
                res_d = rdata_q;
              end else begin
                res_d  = sat;
                wdata  = sat;
                mem_we = 1'b1;
                if (sat_hit) begin
                  stat_d = STAT_SAT;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    mem_we = mem_we && ex_fire;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.kind)
            KIND_WRITE, KIND_READ: state_d = ST_RD;
            KIND_COL, KIND_ACC:    state_d = ST_POS;
            default:               state_d = ST_EX;
          endcase
        end
      end
      ST_POS:  state_d = geom_ok ? ST_ADDR : ST_EX;
      ST_ADDR: state_d = ST_RD;
      ST_RD:   state_d = ST_EX;
      ST_EX:   state_d = ex_fire ? ST_IDLE : ST_EX;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kcol_q      <= '0;
      krow_q      <= '0;
      kch_q       <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      cc_q        <= 7'd1;
      ih_q        <= 7'd1;
      iw_q        <= 7'd1;
      ks_q        <= 4'd1;
      ss_q        <= 4'd1;
      bp_q        <= 4'd0;
    end else begin
      state_q <= state_d;
      if (ex_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      kcol_q <= kcol_d;
      krow_q <= krow_d;
      kch_q  <= kch_d;
      orow_q <= orow_d;
      ocol_q <= ocol_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CHANNELS: cc_q <= cfg_data_i;
          CFG_HEIGHT:   ih_q <= cfg_data_i;
          CFG_WIDTH:    iw_q <= cfg_data_i;
          CFG_KERNEL:   ks_q <= cfg_data_i[3:0];
          CFG_STEP:     ss_q <= cfg_data_i[3:0];
          CFG_PAD:      bp_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      cur_q <= item_i;
    end
    if (state_q == ST_POS) begin
      geom_q   <= geom_ok;
      last_q   <= walk_last;
      inside_q <= in_image;
      r_q      <= prow_r[5:0];
      c_q      <= pcol_c[5:0];
      hch_q    <= hch;
    end
    if (state_q == ST_ADDR) begin
      a_q    <= a_calc;
      aoob_q <= (32'(a_calc) >= STORE_DEPTH);
    end
    if (ex_fire) begin
      res_q  <= res_d;
      src_q  <= src_d;
      inb_q  <= inb_d;
      lst_q  <= lst_d;
      stat_q <= stat_d;
    end
  end

  // image store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_idx] <= wdata;
    end
    if (state_q == ST_RD) begin
      rdata_q <= mem_q[mem_idx];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign source_addr_o  = src_q;
  assign in_bounds_o    = inb_q;
  assign last_element_o = lst_q;
  assign status_o       = stat_q;

  `ITC_ASSERT_IMP(a_write_in_ex, mem_we, state_q == ST_EX)
  `ITC_ASSERT_IMP(a_word_from_ex, $rose(out_valid_q), $past(state_q) == ST_EX)
  `ITC_ASSERT_IMP(a_pop_when_idle, item_pop_o, state_q == ST_IDLE && item_valid_i)
  `ITC_ASSERT_NXT(a_walk_holds, state_q != ST_POS && !rewind_fire, $stable(ocol_q))

endmodule

`default_nettype wire

@@ sv/image_to_column_engine.sv @@
// back-end sequencer, one word at a time: pixel write/read through idle, read, execute;
// im2col and col2im steps through idle, position, address, read, execute (two registered
// address multiplies, then a registered store read; position to execute on a refused
// geometry); rewind and unused codes idle, execute; a stalled result holds execute
// reset: walk counters cleared, geometry to 1,1,1,1,1,0, queue emptied;
// the image store is not cleared and holds garbage until written
`timescale 1ns / 1ps
`default_nettype none

module image_to_column_engine import itc_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [CmdW-1:0]            cmd_i,
  input  logic [PixAddrW-1:0]        pixel_addr_i,
  input  logic signed [DataW-1:0]    data_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DataW-1:0]    result_value_o,
  output logic [PixAddrW-1:0]        source_addr_o,
  output logic                       in_bounds_o,
  output logic                       last_element_o,
  output logic [StatusW-1:0]         status_o,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  item_t item;
  logic  item_valid, item_pop;

  itc_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .pixel_addr_i (pixel_addr_i),
    .data_value_i (data_value_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  itc_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item),
    .item_valid_i   (item_valid),
    .item_pop_o     (item_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .source_addr_o  (source_addr_o),
    .in_bounds_o    (in_bounds_o),
    .last_element_o (last_element_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire
